// ===== rtl/core/mmh_pkg.sv =====
// package for the murmur64b hash stream core: constants, the back-end state
// type, and command and status types shared by front, command queue and back end
`timescale 1ns / 1ps

package mmh_pkg;

  // murmur mixing multiplier and shift amounts
  localparam logic [31:0] MixMul    = 32'h5bd1_e995;
  localparam int unsigned MixShift  = 24;
  localparam int unsigned FinShift1 = 18;
  localparam int unsigned FinShift2 = 22;
  localparam int unsigned FinShift3 = 17;
  localparam int unsigned FinShift4 = 19;

  // command queue between front and back
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // configuration port: byte addresses, one 32-bit register
  localparam int unsigned PaddrW   = 3;
  localparam logic        SeedIdx  = 1'b0;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FULL,
    OP_TAIL
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        first;
    logic        last;
    logic [31:0] word;   // masked for a tail
    logic [31:0] init;   // seed xor length, used on a first beat
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX2,
    S_FOLD,
    S_TAIL,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_FIN4,
    S_EMIT
  } bk_state_e;

endpackage

// ===== rtl/core/mmh_front.sv =====
// front end: takes input beats, tracks message start, builds commands
// depends on mmh_pkg
`timescale 1ns / 1ps

module mmh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mmh_pkg::fifo_stat_t stat_i,
  input  logic [31:0]        seed_i,
  input  logic [31:0]        data_word_i,
  input  logic [2:0]         byte_count_i,
  input  logic               last_i,
  input  logic [31:0]        message_length_i,
  output logic               wr_o,
  output mmh_pkg::cmd_t      cmd_o
);

  logic in_msg_q, in_msg_d;
  logic [31:0] mask;

  assign wr_o = push_i && !stat_i.full;

  always_comb begin
    unique case (byte_count_i[1:0])
      2'd1:    mask = 32'h0000_00ff;
      2'd2:    mask = 32'h0000_ffff;
      2'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    cmd_o.first = !in_msg_q;
    cmd_o.last  = last_i;
    cmd_o.init  = seed_i ^ message_length_i;
    cmd_o.word  = data_word_i;
    // counts of four and above count as a full word
    if (!last_i || byte_count_i[2]) begin
      cmd_o.op = mmh_pkg::OP_FULL;
    end else if (byte_count_i[1:0] != 2'd0) begin
      cmd_o.op   = mmh_pkg::OP_TAIL;
      cmd_o.word = data_word_i & mask;
    end else begin
      cmd_o.op = mmh_pkg::OP_NONE;
    end
  end

  assign in_msg_d = wr_o ? !last_i : in_msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
    end
  end

endmodule

// ===== rtl/core/mmh_cmd_fifo.sv =====
// small command queue between front and back end
// depends on mmh_pkg
`timescale 1ns / 1ps

module mmh_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  mmh_pkg::cmd_t       wr_cmd_i,
  input  logic                rd_i,
  output mmh_pkg::cmd_t       rd_cmd_o,
  output mmh_pkg::fifo_stat_t stat_o
);

  mmh_pkg::cmd_t slot_q [mmh_pkg::CmdDepth];
  logic [mmh_pkg::CmdPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mmh_pkg::CmdCntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == mmh_pkg::CmdCntW'(mmh_pkg::CmdDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rd_cmd_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == mmh_pkg::CmdPtrW'(mmh_pkg::CmdDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == mmh_pkg::CmdPtrW'(mmh_pkg::CmdDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== rtl/core/mmh_back.sv =====
// back end: runs commands through one shared multiplier, finalizes and
// holds the result register; depends on mmh_pkg
`timescale 1ns / 1ps

module mmh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmh_pkg::cmd_t       cmd_i,
  input  mmh_pkg::fifo_stat_t stat_i,
  output logic                rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [63:0]         hash_value_o
);

  mmh_pkg::bk_state_e state_q, state_d;
  logic [31:0] h1_q, h1_d, h2_q, h2_d, k_q, k_d;
  logic        par_q, par_d, last_q, last_d;
  logic        out_vld_q, out_vld_d;
  logic [63:0] hash_q, hash_d;
  logic [31:0] mul_a, mul_p, h1_base, h2_base;
  logic        out_load, out_take;

  assign mul_p    = mul_a * mmh_pkg::MixMul;
  assign out_take = pop_i && out_vld_q;
  assign h1_base  = cmd_i.first ? cmd_i.init : h1_q;
  assign h2_base  = cmd_i.first ? 32'h0 : h2_q;

  always_comb begin
    state_d  = state_q;
    h1_d     = h1_q;
    h2_d     = h2_q;
    k_d      = k_q;
    par_d    = par_q;
    last_d   = last_q;
    hash_d   = hash_q;
    mul_a    = 32'h0;
    rd_o     = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      mmh_pkg::S_IDLE: begin
        if (!stat_i.empty) begin
          rd_o   = 1'b1;
          last_d = cmd_i.last;
          h1_d   = h1_base;
          h2_d   = h2_base;
          par_d  = cmd_i.first ? 1'b0 : par_q;
          unique case (cmd_i.op)
            mmh_pkg::OP_FULL: begin
              mul_a   = cmd_i.word;
              k_d     = mul_p;
              state_d = mmh_pkg::S_MIX2;
            end
            mmh_pkg::OP_TAIL: begin
              h2_d    = h2_base ^ cmd_i.word;
              state_d = mmh_pkg::S_TAIL;
            end
            default: begin
              state_d = mmh_pkg::S_FIN1;
            end
          endcase
        end
      end
      mmh_pkg::S_MIX2: begin
        mul_a   = k_q ^ (k_q >> mmh_pkg::MixShift);
        k_d     = mul_p;
        state_d = mmh_pkg::S_FOLD;
      end
      mmh_pkg::S_FOLD: begin
        if (par_q) begin
          mul_a = h2_q;
          h2_d  = mul_p ^ k_q;
        end else begin
          mul_a = h1_q;
          h1_d  = mul_p ^ k_q;
        end
        par_d   = !par_q;
        state_d = last_q ? mmh_pkg::S_FIN1 : mmh_pkg::S_IDLE;
      end
      mmh_pkg::S_TAIL: begin
        mul_a   = h2_q;
        h2_d    = mul_p;
        state_d = last_q ? mmh_pkg::S_FIN1 : mmh_pkg::S_IDLE;
      end
      mmh_pkg::S_FIN1: begin
        mul_a   = h1_q ^ (h2_q >> mmh_pkg::FinShift1);
        h1_d    = mul_p;
        state_d = mmh_pkg::S_FIN2;
      end
      mmh_pkg::S_FIN2: begin
        mul_a   = h2_q ^ (h1_q >> mmh_pkg::FinShift2);
        h2_d    = mul_p;
        state_d = mmh_pkg::S_FIN3;
      end
      mmh_pkg::S_FIN3: begin
        mul_a   = h1_q ^ (h2_q >> mmh_pkg::FinShift3);
        h1_d    = mul_p;
        state_d = mmh_pkg::S_FIN4;
      end
      mmh_pkg::S_FIN4: begin
        mul_a   = h2_q ^ (h1_q >> mmh_pkg::FinShift4);
        h2_d    = mul_p;
        state_d = mmh_pkg::S_EMIT;
      end
      mmh_pkg::S_EMIT: begin
        if (!out_vld_q || out_take) begin
          out_load = 1'b1;
          hash_d   = {h1_q, h2_q};
          h1_d     = 32'h0;
          h2_d     = 32'h0;
          par_d    = 1'b0;
          state_d  = mmh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mmh_pkg::S_IDLE;
      end
    endcase
  end

  assign out_vld_d    = out_load ? 1'b1 : (out_take ? 1'b0 : out_vld_q);
  assign empty_o      = !out_vld_q;
  assign hash_value_o = hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmh_pkg::S_IDLE;
      par_q     <= 1'b0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
      h1_q      <= 32'h0;
      h2_q      <= 32'h0;
    end else begin
      state_q   <= state_d;
      par_q     <= par_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
      h1_q      <= h1_d;
      h2_q      <= h2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    hash_q <= hash_d;
  end

endmodule

// ===== rtl/core/murmur64b_hash_stream_core.sv =====
// top level of the streaming murmurhash64b core: seed register, front end,
// command queue and back end; depends on mmh_pkg, mmh_front, mmh_cmd_fifo, mmh_back
`timescale 1ns / 1ps

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-----------------------------------
// input     | in        | push / full            | data_word, byte_count, last, message_length
// result    | out       | empty / pop            | hash_value ({h1, h2})
// config    | in        | psel, penable, pwrite  | paddr, pwdata, prdata (seed at 0x0)
//
// back-end states: a full word takes idle, mix2, fold; a tail word idle, tail; an empty
// last beat idle; a last beat adds fin1 to fin4, then emit loads the result register.
// all of these go through the single 32-bit multiply-by-constant in the back end
// a 2-deep command queue lets the front keep taking beats while the back works
// and while a finished hash waits for pop; reset clears seed, control and accumulators

module murmur64b_hash_stream_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input beats
  input  logic                       push,
  output logic                       full,
  input  logic [31:0]                data_word_i,
  input  logic [2:0]                 byte_count_i,
  input  logic                       last_i,
  input  logic [31:0]                message_length_i,
  // results
  output logic                       empty,
  input  logic                       pop,
  output logic [63:0]                hash_value_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mmh_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0]         seed_q, seed_d;
  logic                seed_sel;
  mmh_pkg::cmd_t       fr_cmd, q_cmd;
  mmh_pkg::fifo_stat_t q_stat;
  logic                q_wr, q_rd;

  // seed register, word aligned: the byte offset bits are ignored
  assign pready   = 1'b1;
  assign seed_sel = (paddr[mmh_pkg::PaddrW-1] == mmh_pkg::SeedIdx);
  assign seed_d   = (psel && penable && pwrite && seed_sel) ? pwdata : seed_q;
  assign prdata   = seed_sel ? seed_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 32'h0;
    end else begin
      seed_q <= seed_d;
    end
  end

  // front: classifies each beat as full word, tail or empty last
  mmh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .stat_i           (q_stat),
    .seed_i           (seed_q),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .last_i           (last_i),
    .message_length_i (message_length_i),
    .wr_o             (q_wr),
    .cmd_o            (fr_cmd)
  );

  assign full = q_stat.full;

  // decoupling queue
  mmh_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_cmd_i (fr_cmd),
    .rd_i     (q_rd),
    .rd_cmd_o (q_cmd),
    .stat_o   (q_stat)
  );

  // back: mixing, folding, finalize and the result register
  mmh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_cmd),
    .stat_i       (q_stat),
    .rd_o         (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .hash_value_o (hash_value_o)
  );

`ifndef SYNTH
  // queue never written when full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> !q_stat.full) else $error("command queue overflow");

  // back end never reads an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_stat.empty) else $error("command queue underflow");

  // the beat after a last beat opens a new message
  a_new_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && last_i) |=> fr_cmd.first)
    else $error("message start not flagged after last beat");
`endif

endmodule
